// ===== rtl/sts_pkg.sv =====
// Shared types, codes and character helpers for the SQL token scanner.
package sts_pkg;

    // Default width of the line and column counters
    localparam int STS_POS_W_DEF = 16;
    // Width of the line and column fields on the result words
    localparam int STS_POS_OUT_W = 16;
    // Most result words one input word can cause
    localparam int STS_MAX_RES   = 3;
    // Depth of the bundle queue between scanner and serializer
    localparam int STS_QDEPTH    = 4;

    // Result kinds
    localparam logic [1:0] RK_BYTE  = 2'd0;
    localparam logic [1:0] RK_TOKEN = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // Token kinds
    localparam logic [4:0] TK_EOF    = 5'd0;
    localparam logic [4:0] TK_IDENT  = 5'd1;
    localparam logic [4:0] TK_NUMBER = 5'd2;
    localparam logic [4:0] TK_STRING = 5'd3;
    localparam logic [4:0] TK_KW0    = 5'd4;
    localparam logic [4:0] TK_COMMA  = 5'd12;
    localparam logic [4:0] TK_STAR   = 5'd13;
    localparam logic [4:0] TK_LPAREN = 5'd14;
    localparam logic [4:0] TK_RPAREN = 5'd15;
    localparam logic [4:0] TK_SEMI   = 5'd16;
    localparam logic [4:0] TK_EQUAL  = 5'd17;

    // Error codes
    localparam logic [1:0] EC_UNEXPECTED = 2'd0;
    localparam logic [1:0] EC_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] EC_UNTERM     = 2'd2;

    // Keywords, first character in the top byte, zero padded
    localparam logic [47:0] KW_WORD [8] = '{
        "INSERT", {"INTO", 16'h0}, "VALUES", "SELECT",
        {"FROM", 16'h0}, {"WHERE", 8'h0}, {"TRUE", 16'h0}, {"FALSE", 8'h0}
    };
    localparam logic [2:0] KW_LEN [8] = '{3'd6, 3'd4, 3'd6, 3'd6, 3'd4, 3'd5, 3'd4, 3'd5};

    // One result word
    typedef struct packed {
        logic [1:0]               kind;
        logic [7:0]               lexeme;
        logic [4:0]               tok;
        logic [STS_POS_OUT_W-1:0] line;
        logic [STS_POS_OUT_W-1:0] col;
        logic [1:0]               ecode;
    } sts_result_t;

    // All results of one input word
    typedef struct packed {
        sts_result_t [STS_MAX_RES-1:0] res;
        logic [1:0]                    cnt;
    } sts_bundle_t;

    // Queue status toward the scanner and serializer
    typedef struct packed {
        logic full;
        logic empty;
    } sts_q_status_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) ? (b - 8'd32) : b;
    endfunction

    // Character of keyword k at position pos (pos below 6)
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [47:0] w;
        w = KW_WORD[k];
        return w[8 * (5 - int'(pos)) +: 8];
    endfunction

    // Punctuator token kind, TK_EOF when the byte is none
    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] tk;
        tk = TK_EOF;
        unique case (b)
            ",":     tk = TK_COMMA;
            "*":     tk = TK_STAR;
            "(":     tk = TK_LPAREN;
            ")":     tk = TK_RPAREN;
            ";":     tk = TK_SEMI;
            "=":     tk = TK_EQUAL;
            default: tk = TK_EOF;
        endcase
        return tk;
    endfunction

    function automatic sts_result_t mk_byte(input logic [7:0] b);
        sts_result_t r;
        r        = '0;
        r.kind   = RK_BYTE;
        r.lexeme = b;
        return r;
    endfunction

    function automatic sts_result_t mk_token(input logic [4:0] tk,
                                             input logic [STS_POS_OUT_W-1:0] line,
                                             input logic [STS_POS_OUT_W-1:0] col);
        sts_result_t r;
        r      = '0;
        r.kind = RK_TOKEN;
        r.tok  = tk;
        r.line = line;
        r.col  = col;
        return r;
    endfunction

    function automatic sts_result_t mk_err(input logic [STS_POS_OUT_W-1:0] line,
                                           input logic [STS_POS_OUT_W-1:0] col,
                                           input logic [1:0] ec);
        sts_result_t r;
        r       = '0;
        r.kind  = RK_ERROR;
        r.line  = line;
        r.col   = col;
        r.ecode = ec;
        return r;
    endfunction

endpackage

// ===== rtl/sts_front.sv =====
// Front end: lexer state machine, one accepted word per cycle into result bundles.
module sts_front import sts_pkg::*; #(
    parameter int POSITION_WIDTH = STS_POS_W_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        operation,
    input  logic [7:0]  text_byte,
    output logic        push,
    output sts_bundle_t push_bundle
);

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_MINUS, M_STRING, M_ESCAPE, M_ERROR
    } mode_t;

    typedef logic [POSITION_WIDTH-1:0] pos_t;

    mode_t      mode_reg, mode_next;
    pos_t       cur_line_reg, cur_line_next;
    pos_t       cur_col_reg, cur_col_next;
    pos_t       start_line_reg, start_line_next;
    pos_t       start_col_reg, start_col_next;
    logic [7:0] mask_reg, mask_next;
    logic [2:0] len_reg, len_next;

    logic [STS_POS_OUT_W-1:0] cur_line_o, cur_col_o, start_line_o, start_col_o;
    logic [4:0]               ident_kind;
    logic [7:0]               up_byte;

    assign cur_line_o   = STS_POS_OUT_W'(cur_line_reg);
    assign cur_col_o    = STS_POS_OUT_W'(cur_col_reg);
    assign start_line_o = STS_POS_OUT_W'(start_line_reg);
    assign start_col_o  = STS_POS_OUT_W'(start_col_reg);
    assign up_byte      = to_upper(text_byte);

    // Kind of the open identifier: first keyword still matching at its full length
    always_comb begin
        ident_kind = TK_IDENT;
        for (int k = 7; k >= 0; k--) begin
            if (mask_reg[k] && (KW_LEN[k] == len_reg)) begin
                ident_kind = TK_KW0 + 5'(k);
            end
        end
    end

    // Next state and the results of the accepted word
    always_comb begin
        sts_bundle_t bnd;
        logic [1:0]  n;
        logic        run_idle;
        logic        feed_en;
        logic [7:0]  base_mask;
        logic [2:0]  base_len;
        logic [7:0]  fed_mask;
        logic [4:0]  pk;

        bnd             = '0;
        n               = '0;
        run_idle        = 1'b0;
        feed_en         = 1'b0;
        base_mask       = mask_reg;
        base_len        = len_reg;
        fed_mask        = '0;
        pk              = punct_kind(text_byte);
        mode_next       = mode_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        mask_next       = mask_reg;
        len_next        = len_reg;

        if (accept) begin
            if (operation) begin
                // end of text: close or flag the open token, then back to reset values
                unique case (mode_reg)
                    M_IDENT: begin
                        bnd.res[n] = mk_token(ident_kind, start_line_o, start_col_o);
                        n = n + 2'd1;
                        bnd.res[n] = mk_token(TK_EOF, cur_line_o, cur_col_o);
                        n = n + 2'd1;
                    end
                    M_NUMBER: begin
                        bnd.res[n] = mk_token(TK_NUMBER, start_line_o, start_col_o);
                        n = n + 2'd1;
                        bnd.res[n] = mk_token(TK_EOF, cur_line_o, cur_col_o);
                        n = n + 2'd1;
                    end
                    M_IDLE: begin
                        bnd.res[n] = mk_token(TK_EOF, cur_line_o, cur_col_o);
                        n = n + 2'd1;
                    end
                    M_MINUS: begin
                        bnd.res[n] = mk_err(start_line_o, start_col_o, EC_UNEXPECTED);
                        n = n + 2'd1;
                    end
                    M_STRING: begin
                        bnd.res[n] = mk_err(start_line_o, start_col_o, EC_UNTERM);
                        n = n + 2'd1;
                    end
                    M_ESCAPE: begin
                        bnd.res[n] = mk_err(cur_line_o, cur_col_o, EC_BAD_ESCAPE);
                        n = n + 2'd1;
                    end
                    default: ;
                endcase
                mode_next       = M_IDLE;
                cur_line_next   = pos_t'(1);
                cur_col_next    = pos_t'(1);
                start_line_next = pos_t'(1);
                start_col_next  = pos_t'(1);
                mask_next       = '1;
                len_next        = '0;
            end else begin
                unique case (mode_reg)
                    M_IDLE: run_idle = 1'b1;
                    M_IDENT: begin
                        if (is_alpha(text_byte) || is_digit(text_byte) || text_byte == "_") begin
                            feed_en    = 1'b1;
                            bnd.res[n] = mk_byte(text_byte);
                            n = n + 2'd1;
                        end else begin
                            bnd.res[n] = mk_token(ident_kind, start_line_o, start_col_o);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                            run_idle  = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(text_byte)) begin
                            bnd.res[n] = mk_byte(text_byte);
                            n = n + 2'd1;
                        end else begin
                            bnd.res[n] = mk_token(TK_NUMBER, start_line_o, start_col_o);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                            run_idle  = 1'b1;
                        end
                    end
                    M_MINUS: begin
                        if (is_digit(text_byte)) begin
                            bnd.res[n] = mk_byte("-");
                            n = n + 2'd1;
                            bnd.res[n] = mk_byte(text_byte);
                            n = n + 2'd1;
                            mode_next = M_NUMBER;
                        end else begin
                            bnd.res[n] = mk_err(start_line_o, start_col_o, EC_UNEXPECTED);
                            n = n + 2'd1;
                            mode_next = M_ERROR;
                        end
                    end
                    M_STRING: begin
                        priority if (text_byte == "'") begin
                            bnd.res[n] = mk_token(TK_STRING, start_line_o, start_col_o);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end else if (text_byte == "\\") begin
                            mode_next = M_ESCAPE;
                        end else if (text_byte == 8'd10) begin
                            bnd.res[n] = mk_err(start_line_o, start_col_o, EC_UNTERM);
                            n = n + 2'd1;
                            mode_next = M_ERROR;
                        end else begin
                            bnd.res[n] = mk_byte(text_byte);
                            n = n + 2'd1;
                        end
                    end
                    M_ESCAPE: begin
                        priority if (text_byte == "n") begin
                            bnd.res[n] = mk_byte(8'd10);
                            n = n + 2'd1;
                            mode_next = M_STRING;
                        end else if (text_byte == "t") begin
                            bnd.res[n] = mk_byte(8'd9);
                            n = n + 2'd1;
                            mode_next = M_STRING;
                        end else if (text_byte == "\\" || text_byte == "'") begin
                            bnd.res[n] = mk_byte(text_byte);
                            n = n + 2'd1;
                            mode_next = M_STRING;
                        end else begin
                            bnd.res[n] = mk_err(cur_line_o, cur_col_o, EC_BAD_ESCAPE);
                            n = n + 2'd1;
                            mode_next = M_ERROR;
                        end
                    end
                    default: ;
                endcase

                // start of a new token, also right after a closed identifier or number
                if (run_idle) begin
                    priority if (is_space(text_byte)) begin
                    end else if (is_alpha(text_byte) || text_byte == "_") begin
                        start_line_next = cur_line_reg;
                        start_col_next  = cur_col_reg;
                        base_mask  = '1;
                        base_len   = '0;
                        feed_en    = 1'b1;
                        bnd.res[n] = mk_byte(text_byte);
                        n = n + 2'd1;
                        mode_next  = M_IDENT;
                    end else if (is_digit(text_byte)) begin
                        start_line_next = cur_line_reg;
                        start_col_next  = cur_col_reg;
                        bnd.res[n] = mk_byte(text_byte);
                        n = n + 2'd1;
                        mode_next  = M_NUMBER;
                    end else if (text_byte == "-") begin
                        start_line_next = cur_line_reg;
                        start_col_next  = cur_col_reg;
                        mode_next  = M_MINUS;
                    end else if (text_byte == "'") begin
                        start_line_next = cur_line_reg;
                        start_col_next  = cur_col_reg;
                        mode_next  = M_STRING;
                    end else if (pk != TK_EOF) begin
                        start_line_next = cur_line_reg;
                        start_col_next  = cur_col_reg;
                        bnd.res[n] = mk_byte(text_byte);
                        n = n + 2'd1;
                        bnd.res[n] = mk_token(pk, cur_line_o, cur_col_o);
                        n = n + 2'd1;
                    end else begin
                        bnd.res[n] = mk_err(cur_line_o, cur_col_o, EC_UNEXPECTED);
                        n = n + 2'd1;
                        mode_next  = M_ERROR;
                    end
                end

                // keyword mask: keep keywords whose next character matches
                if (feed_en) begin
                    if (base_len < 3'd6) begin
                        for (int k = 0; k < 8; k++) begin
                            fed_mask[k] = base_mask[k] &&
                                          (kw_char(3'(k), base_len) == up_byte);
                        end
                    end
                    mask_next = fed_mask;
                    len_next  = (base_len < 3'd7) ? (base_len + 3'd1) : base_len;
                end

                // position tracking, saturating; frozen once in error
                if (mode_next != M_ERROR) begin
                    if (text_byte == 8'd10) begin
                        if (cur_line_reg != '1) begin
                            cur_line_next = cur_line_reg + pos_t'(1);
                        end
                        cur_col_next = pos_t'(1);
                    end else if (cur_col_reg != '1) begin
                        cur_col_next = cur_col_reg + pos_t'(1);
                    end
                end
            end
        end

        bnd.cnt     = n;
        push_bundle = bnd;
        push        = accept && (n != 2'd0);
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            cur_line_reg   <= pos_t'(1);
            cur_col_reg    <= pos_t'(1);
            start_line_reg <= pos_t'(1);
            start_col_reg  <= pos_t'(1);
            mask_reg       <= '1;
            len_reg        <= '0;
        end else begin
            mode_reg       <= mode_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            mask_reg       <= mask_next;
            len_reg        <= len_next;
        end
    end

endmodule

// ===== rtl/sts_queue.sv =====
// Short bundle queue between scanner and result serializer.
module sts_queue import sts_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sts_bundle_t   push_bundle,
    input  logic          pop,
    output sts_bundle_t   head,
    output sts_q_status_t status
);

    localparam int PTR_W = $clog2(STS_QDEPTH);
    localparam int CNT_W = $clog2(STS_QDEPTH + 1);

    sts_bundle_t      slot_reg [STS_QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(STS_QDEPTH));
    assign status.empty = (count_reg == '0);

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(STS_QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(STS_QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

// ===== rtl/sts_back.sv =====
// Result serializer: walks each bundle into the output register one word per cycle unless stalled.
module sts_back import sts_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  sts_bundle_t   head,
    input  sts_q_status_t q_status,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // lexeme_byte, token_kind, token_line, token_column, error_code
    output logic [1:0]    m_tuser,   // result_kind
    output logic          m_tlast    // last_of_run
);

    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    sts_result_t word_reg;
    logic        last_reg;
    logic        load;
    logic        at_last;

    assign load    = (!valid_reg || m_tready) && !q_status.empty;
    assign at_last = (idx_reg == (head.cnt - 2'd1));
    assign pop     = load && at_last;

    // Output register control and bundle index
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : (idx_reg + 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= head.res[idx_reg];
            last_reg <= at_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = word_reg.kind;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, word_reg.ecode, word_reg.col, word_reg.line,
                       word_reg.tok, word_reg.lexeme};

endmodule

// ===== rtl/sql_token_scanner_top.sv =====
// Top level of the streaming SQL token scanner.
//
// Input words carry one byte of statement text (s_tdata) or, with s_tuser set,
// the end of the statement. Output words are lexeme bytes, token-complete words
// (kind and start position) and error words, selected by m_tuser; m_tlast marks
// the final output word caused by one input word.
// A byte is accepted at every edge where s_tvalid and s_tready are high; the
// scanner takes one word per cycle while s_tready is high. Each input word
// yields zero to three output words, which leave at one per cycle through the
// output register while m_tready is high, so the input rate is one word per
// cycle as long as words average at most one result; the output port sets the
// limit otherwise. The first result word of an input word is registered in the
// bundle queue, then in the output register, before it shows on m_tvalid.
// A four-entry bundle queue sits between scanner and serializer: when m_tready
// is held low the queue fills and s_tready drops, and no word is lost.
// After an error, text bytes are dropped until the end word, which emits nothing
// and returns the scanner to its reset state. aresetn (synchronous, active low)
// empties the queue and output and sets line and column to 1.
module sql_token_scanner_top import sts_pkg::*; #(
    parameter int POSITION_WIDTH = STS_POS_W_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic [0:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // lexeme_byte, token_kind, token_line, token_column, error_code
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_of_run
);

    sts_q_status_t q_status;
    sts_bundle_t   push_bundle;
    sts_bundle_t   head;
    logic          push;
    logic          pop;
    logic          accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    sts_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .operation   (s_tuser[0]),
        .text_byte   (s_tdata),
        .push        (push),
        .push_bundle (push_bundle)
    );

    sts_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .status      (q_status)
    );

    sts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
